[rtl/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, quiet while reset is high.
`define SFR_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("stream find/replace check failed");

// Concurrent check that also runs across reset.
`define SFR_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("stream find/replace reset check failed");

`endif

[rtl/sfr_pkg.sv]
package sfr_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_PATTERN            = 3'd0;
  localparam logic [2:0] REG_PATTERN_LENGTH     = 3'd1;
  localparam logic [2:0] REG_REPLACEMENT        = 3'd2;
  localparam logic [2:0] REG_REPLACEMENT_LENGTH = 3'd3;

  // one result item
  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       last;
  } res_t;

  // window row control
  typedef struct packed {
    logic en;     // an input item is taken this cycle
    logic shift;  // oldest byte leaves, row moves toward cell 0
  } win_ctl_t;

  // output row control
  typedef struct packed {
    logic load;   // parallel load of a new burst
    logic pop;    // head item taken, row moves toward cell 0
  } out_ctl_t;

endpackage

[rtl/sfr_win_cell.sv]
module sfr_win_cell (
  input  logic              clk,
  input  sfr_pkg::win_ctl_t ctl,
  input  logic              ins,
  input  logic [7:0]        in_byte,
  input  logic [7:0]        nbr_byte,
  input  logic [7:0]        pat_byte,
  output logic [7:0]        cur_byte,
  output logic              eq
);

  logic [7:0] held;

  // the incoming byte lands in the cell at the current fill position
  assign cur_byte = ins ? in_byte : held;
  assign eq       = (cur_byte == pat_byte);

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      held <= ctl.shift ? nbr_byte : cur_byte;
    end
  end

endmodule

[rtl/sfr_out_cell.sv]
module sfr_out_cell (
  input  logic              clk,
  input  sfr_pkg::out_ctl_t ctl,
  input  sfr_pkg::res_t     load_val,
  input  sfr_pkg::res_t     nbr_val,
  output sfr_pkg::res_t     cur_val
);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cur_val <= load_val;
    end else if (ctl.pop) begin
      cur_val <= nbr_val;
    end
  end

endmodule

[rtl/stream_find_replace_core.sv]
// Streaming find-and-replace. Bytes of a string enter on the slave side,
// the last one of the string flagged by tlast, and every leftmost,
// non-overlapping occurrence of the programmed pattern is replaced by the
// programmed replacement on the master side. tuser marks whether tdata
// carries a byte (low only on an empty end marker, sent when the final
// item of a string yields no byte). While the master side takes each
// result, an item that yields at most one result is taken every cycle,
// so plain text flows at one byte per clock, each result offered in the
// cycle after its item; an item that yields n results (a replacement
// burst, or the end flush) holds tready low as they drain one per clock.
// The pending bytes sit in a row of PATTERN_MAX window cells, each
// comparing its byte against its pattern byte; results are loaded in
// parallel into a row of output cells that shift toward the head.
// Program registers only while the stream is idle; writing pattern_length
// discards any pending window bytes. Lengths above PATTERN_MAX or
// REPLACE_MAX saturate, and a zero pattern_length passes bytes through.
module stream_find_replace_core #(
  parameter int PATTERN_MAX = 8,   // 1..8
  parameter int REPLACE_MAX = 8    // 1..8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // end_of_string
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tuser,   // [0] has_byte
  output logic        m_axis_tlast,   // last
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [63:0] wr_data
);

  localparam int OUT_DEPTH = (PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX;
  localparam int CW        = $clog2(PATTERN_MAX + 1);
  localparam int OCW       = $clog2(OUT_DEPTH + 1);

  // configuration
  logic [63:0] pattern;
  logic [3:0]  plen;
  logic [63:0] replacement;
  logic [3:0]  rlen;

  // window fill and output row fill
  logic [CW-1:0]  cnt;
  logic [CW-1:0]  cnt_next;
  logic [OCW-1:0] ocnt;
  logic [OCW-1:0] ocnt_next;

  logic accept;
  logic pop;
  logic eos;

  logic [3:0] pl_eff;
  logic [3:0] rl_eff;
  logic [3:0] cnt4;
  logic [3:0] cnt_eff;
  logic [3:0] cnt_new;
  logic       pl_zero;
  logic       full;
  logic       match;
  logic [3:0] n_raw;
  logic [3:0] n_fin;

  logic [7:0]             wp [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] eq;
  logic [PATTERN_MAX-1:0] in_use;
  logic [PATTERN_MAX-1:0] ins;

  logic [7:0] win_pad [OUT_DEPTH];
  logic [7:0] rep_pad [OUT_DEPTH];

  sfr_pkg::win_ctl_t win_ctl;
  sfr_pkg::out_ctl_t out_ctl;
  sfr_pkg::res_t     load_val [OUT_DEPTH];
  sfr_pkg::res_t     oq       [OUT_DEPTH];

  assign eos    = s_axis_tlast;
  assign pop    = m_axis_tvalid && m_axis_tready;
  // take a new item when the output row is empty or empties this cycle
  assign s_axis_tready = (ocnt == '0) || ((ocnt == OCW'(1)) && pop);
  assign accept = s_axis_tvalid && s_axis_tready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern     <= '0;
      plen        <= '0;
      replacement <= '0;
      rlen        <= '0;
    end else if (wr_en) begin
      case (wr_index)
        sfr_pkg::REG_PATTERN:            pattern     <= wr_data;
        sfr_pkg::REG_PATTERN_LENGTH:     plen        <= wr_data[3:0];
        sfr_pkg::REG_REPLACEMENT:        replacement <= wr_data;
        sfr_pkg::REG_REPLACEMENT_LENGTH: rlen        <= wr_data[3:0];
        default: ;
      endcase
    end
  end

  // saturated lengths and fill position of the new byte
  always_comb begin
    pl_eff  = (plen > 4'(PATTERN_MAX)) ? 4'(PATTERN_MAX) : plen;
    rl_eff  = (rlen > 4'(REPLACE_MAX)) ? 4'(REPLACE_MAX) : rlen;
    pl_zero = (pl_eff == 4'd0);
    cnt4    = 4'(cnt);
    // a stale fill (cannot occur after a length write) restarts the window
    cnt_eff = ((cnt4 >= 4'(PATTERN_MAX)) || (!pl_zero && (cnt4 >= pl_eff))) ? 4'd0 : cnt4;
    cnt_new = cnt_eff + 4'd1;
    full    = pl_zero || (cnt_new == pl_eff);
  end

  // window row
  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_win
    logic [7:0] nbr;
    if (i == PATTERN_MAX - 1) begin : g_end
      assign nbr = wp[i];
    end else begin : g_mid
      assign nbr = wp[i+1];
    end
    assign ins[i]    = (cnt_eff == 4'(i));
    assign in_use[i] = (4'(i) < pl_eff);

    sfr_win_cell u_cell (
      .clk      (clk),
      .ctl      (win_ctl),
      .ins      (ins[i]),
      .in_byte  (s_axis_tdata),
      .nbr_byte (nbr),
      .pat_byte (pattern[8*i +: 8]),
      .cur_byte (wp[i]),
      .eq       (eq[i])
    );
  end

  assign match         = !pl_zero && full && (&(eq | ~in_use));
  assign win_ctl.en    = accept;
  assign win_ctl.shift = full && !match && !pl_zero;

  // window fill update
  always_comb begin
    if (match || eos || pl_zero) begin
      cnt_next = '0;
    end else if (full) begin
      cnt_next = CW'(cnt_new - 4'd1);
    end else begin
      cnt_next = CW'(cnt_new);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (wr_en && (wr_index == sfr_pkg::REG_PATTERN_LENGTH)) begin
      cnt <= '0;
    end else if (accept) begin
      cnt <= cnt_next;
    end
  end

  // burst for this item: replacement bytes on a match, else the oldest
  // byte when full, else nothing; end of string flushes the whole window
  always_comb begin
    for (int k = 0; k < OUT_DEPTH; k++) begin
      win_pad[k] = 8'd0;
      rep_pad[k] = 8'd0;
    end
    for (int k = 0; k < PATTERN_MAX; k++) begin
      win_pad[k] = wp[k];
    end
    for (int k = 0; k < REPLACE_MAX; k++) begin
      rep_pad[k] = replacement[8*k +: 8];
    end

    if (match) begin
      n_raw = rl_eff;
    end else if (eos || pl_zero) begin
      n_raw = cnt_new;
    end else begin
      n_raw = full ? 4'd1 : 4'd0;
    end
    // empty end marker when the final item yields no byte
    n_fin = (eos && (n_raw == 4'd0)) ? 4'd1 : n_raw;

    for (int k = 0; k < OUT_DEPTH; k++) begin
      load_val[k].data = match ? rep_pad[k] : win_pad[k];
      load_val[k].has  = 1'b1;
      load_val[k].last = eos && ((4'(k) + 4'd1) == n_fin);
    end
    if (eos && (n_raw == 4'd0)) begin
      load_val[0].data = 8'd0;
      load_val[0].has  = 1'b0;
    end
  end

  // output row
  assign out_ctl.load = accept;
  assign out_ctl.pop  = pop;

  for (genvar k = 0; k < OUT_DEPTH; k++) begin : g_out
    sfr_pkg::res_t nbr;
    if (k == OUT_DEPTH - 1) begin : g_end
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = oq[k+1];
    end

    sfr_out_cell u_cell (
      .clk      (clk),
      .ctl      (out_ctl),
      .load_val (load_val[k]),
      .nbr_val  (nbr),
      .cur_val  (oq[k])
    );
  end

  always_comb begin
    if (accept) begin
      ocnt_next = OCW'(n_fin);
    end else if (pop) begin
      ocnt_next = ocnt - OCW'(1);
    end else begin
      ocnt_next = ocnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ocnt <= '0;
    end else begin
      ocnt <= ocnt_next;
    end
  end

  assign m_axis_tvalid = (ocnt != '0);
  assign m_axis_tdata  = oq[0].data;
  assign m_axis_tuser  = oq[0].has;
  assign m_axis_tlast  = oq[0].last;

endmodule

[rtl/sfr_checker.sv]
`include "assert_macros.svh"

module sfr_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tuser,
  input logic       m_axis_tlast
);

  // a result waiting to be taken stays offered
  `SFR_ASSERT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)

  // an empty end marker only closes a string
  `SFR_ASSERT(a_empty_is_last, clk, rst, m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)

  // an empty end marker carries a zero byte
  `SFR_ASSERT(a_empty_is_zero, clk, rst, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 8'd0)

  // no new item while a result is stalled
  `SFR_ASSERT(a_stall_blocks_in, clk, rst, m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)

  // nothing is offered right after reset
  `SFR_ASSERT_RST(a_reset_empty, clk, rst |=> !m_axis_tvalid)

endmodule

bind stream_find_replace_core sfr_checker u_sfr_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
